### design/mfed_pkg.sv
// ----------------------------------------------------------------------------
// mfed_pkg
// Shared types and constants of the monochrome frame store drawing engine.
// ----------------------------------------------------------------------------
package mfed_pkg;

    localparam int PANEL_WIDTH = 128;
    localparam int PANEL_PAGES = 8;
    localparam int STORE_BYTES = PANEL_PAGES * PANEL_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int ROWS_FULL   = PANEL_PAGES * 8;
    localparam int ROWS_HALF   = PANEL_PAGES * 4;
    localparam int COORD_W     = 10;
    localparam int PT_W        = 13;
    localparam int DEC_W       = 48;
    localparam int MUL_W       = 22;
    localparam int MUL_P       = 2 * MUL_W;

    typedef enum logic [1:0] {
        FN_SET     = 2'd0,
        FN_ELLIPSE = 2'd1,
        FN_READ    = 2'd2,
        FN_CLEAR   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        MD_OR     = 2'd0,
        MD_ANDNOT = 2'd1,
        MD_XOR    = 2'd2,
        MD_KEEP   = 2'd3
    } t_mode;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_E_GEO,
        ST_E_RX2,
        ST_E_RY2,
        ST_E_T,
        ST_E_INIT,
        ST_R1_TEST,
        ST_R1_UPD,
        ST_D2_A,
        ST_D2_B,
        ST_D2_C,
        ST_D2_D,
        ST_D2_E,
        ST_R2_TEST,
        ST_R2_UPD,
        ST_PX_RD,
        ST_PX_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_ram_req;

    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        mask;
    } t_pix;

    typedef struct packed {
        logic       done;
        logic [7:0] read_data;
    } t_done;

endpackage

### design/mfed_if.sv
// ----------------------------------------------------------------------------
// mfed_cmd_if / mfed_rsp_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface mfed_cmd_if;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic signed [9:0] corner_x0;
    logic signed [9:0] corner_y0;
    logic signed [9:0] corner_x1;
    logic signed [9:0] corner_y1;
    logic [1:0]        draw_mode;
    logic [9:0]        read_address;

    modport source(output valid, func, corner_x0, corner_y0, corner_x1, corner_y1,
                   draw_mode, read_address, input ready);
    modport sink(input valid, func, corner_x0, corner_y0, corner_x1, corner_y1,
                 draw_mode, read_address, output ready);
endinterface

interface mfed_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       command_done;

    modport source(output valid, read_data, command_done, input ready);
    modport sink(input valid, read_data, command_done, output ready);
endinterface

### design/monochrome_framebuffer_ellipse_drawer.sv
// ----------------------------------------------------------------------------
// monochrome_framebuffer_ellipse_drawer
// Drawing engine over a page-organized one-bit frame store.
//
// Commands arrive as items on i_cmd: set pixel, ellipse outline, read byte
// and clear. Each command yields one item on o_rsp carrying read_data (the
// store byte for a read, zero otherwise) and command_done.
// One command is in work at a time; the frame store is a single-port memory
// with registered read data, and every plotted pixel takes a read and a write
// on that port. An ellipse runs its setup steps and then, per traced point, a
// test step, an update step, a read and a write for each of its four
// symmetric pixels that falls on the panel and a skip step for each that
// falls off it.
// After reset the block sweeps zeros through all 1024 bytes before it takes
// the first command; i_cfg_we is honored throughout.
// A result waits in an output register while the receiver stalls; the next
// command may be accepted meanwhile, but its result waits for the register.
// ----------------------------------------------------------------------------
module monochrome_framebuffer_ellipse_drawer
    import mfed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    mfed_cmd_if.sink   i_cmd,
    mfed_rsp_if.source o_rsp
);

    logic       r_half;
    logic       r_valid;
    logic [7:0] r_rdata;
    logic       rsp_free;
    logic [7:0] ram_rdata;
    t_ram_req   ram_req;
    t_done      done;

    assign rsp_free = !r_valid || o_rsp.ready;

    mfed_ram u_ram (
        .i_clk  (i_clk),
        .i_req  (ram_req),
        .o_rdata(ram_rdata)
    );

    mfed_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .i_half    (r_half),
        .i_rsp_free(rsp_free),
        .i_rdata   (ram_rdata),
        .o_req     (ram_req),
        .o_done    (done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_half <= i_cfg_wdata;
            end
            if (done.done) begin
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (done.done) begin
            r_rdata <= done.read_data;
        end
    end

    assign o_rsp.valid        = r_valid;
    assign o_rsp.read_data    = r_rdata;
    assign o_rsp.command_done = 1'b1;

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_req.we && ram_req.re))
        else $error("frame store read and write in the same cycle");

    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_cmd.ready)
        else $error("command taken during the clearing pass");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("second command taken while one is in work");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_rsp.ready) |-> !done.done)
        else $error("result register overwritten while stalled");

endmodule

### design/mfed_ram.sv
// ----------------------------------------------------------------------------
// mfed_ram
// Single-port frame store with registered read data.
// ----------------------------------------------------------------------------
module mfed_ram
    import mfed_pkg::*;
(
    input  logic       i_clk,
    input  t_ram_req   i_req,
    output logic [7:0] o_rdata
);

    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/mfed_pixel.sv
// ----------------------------------------------------------------------------
// mfed_pixel
// Clips a pixel to the panel and maps it to a store byte and bit mask.
// ----------------------------------------------------------------------------
module mfed_pixel
    import mfed_pkg::*;
(
    input  logic signed [PT_W-1:0] i_px,
    input  logic signed [PT_W-1:0] i_py,
    input  logic                   i_half,
    output t_pix                   o_pix
);

    logic [31:0] ux;
    logic [31:0] uy;
    logic [31:0] rows;
    logic [31:0] row;
    logic [31:0] addr;

    always_comb begin
        ux   = 32'($unsigned(i_px));
        uy   = 32'($unsigned(i_py));
        rows = i_half ? 32'(ROWS_HALF) : 32'(ROWS_FULL);
        row  = i_half ? ((uy << 1) + 32'd1) : uy;
        addr = ux + (row >> 3) * 32'(PANEL_WIDTH);
        o_pix.hit  = !i_px[PT_W-1] && !i_py[PT_W-1] &&
                     (ux < 32'(PANEL_WIDTH)) && (uy < rows);
        o_pix.addr = addr[ADDR_W-1:0];
        o_pix.mask = i_half ? (8'b0000_0011 << {row[2:1], 1'b0}) : (8'b0000_0001 << row[2:0]);
    end

endmodule

### design/mfed_ctrl.sv
// ----------------------------------------------------------------------------
// mfed_ctrl
// Command sequencer: clear sweep, byte read, pixel read-modify-write and the
// two-region midpoint ellipse tracer on a shared multiplier.
// ----------------------------------------------------------------------------
module mfed_ctrl
    import mfed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mfed_cmd_if.sink   i_cmd,
    input  logic       i_half,
    input  logic       i_rsp_free,
    input  logic [7:0] i_rdata,
    output t_ram_req   o_req,
    output t_done      o_done
);

    t_state                   r_state, n_state;
    t_state                   r_ret, n_ret;
    logic [ADDR_W-1:0]        r_clr, n_clr;
    logic                     r_clr_cmd, n_clr_cmd;
    t_func                    r_func, n_func;
    t_mode                    r_mode, n_mode;
    logic signed [9:0]        r_x0, n_x0, r_y0, n_y0, r_x1, n_x1, r_y1, n_y1;
    logic [9:0]               r_raddr, n_raddr;
    logic [9:0]               r_rx, n_rx, r_ry, n_ry;
    logic signed [11:0]       r_xc, n_xc, r_yc, n_yc;
    logic [10:0]              r_x, n_x;
    logic signed [11:0]       r_y, n_y;
    logic signed [DEC_W-1:0]  r_rx2, n_rx2, r_ry2, n_ry2;
    logic [MUL_P-1:0]         r_t, n_t;
    logic signed [DEC_W-1:0]  r_d, n_d, r_dx, n_dx, r_dy, n_dy;
    logic [1:0]               r_k, n_k;
    logic [ADDR_W-1:0]        r_paddr, n_paddr;
    logic [7:0]               r_pmask, n_pmask;
    logic [7:0]               r_rdata, n_rdata;

    logic [MUL_W-1:0]         m_a, m_b;
    logic [MUL_P-1:0]         m_p;
    logic signed [DEC_W-1:0]  pe, te, dxn, dyn;
    logic signed [10:0]       ddx, ddy;
    logic [10:0]              adx, ady;
    logic signed [11:0]       ym1;
    logic [11:0]              aym1;
    logic signed [PT_W-1:0]   px, py, xo, yo, xce, yce;
    logic                     rd_hit;
    logic [7:0]               wbyte;
    t_pix                     pix;

    mfed_pixel u_pixel (
        .i_px  (px),
        .i_py  (py),
        .i_half(i_half),
        .o_pix (pix)
    );

    assign i_cmd.ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_clr_cmd <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_clr_cmd <= n_clr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret   <= n_ret;
        r_func  <= n_func;
        r_mode  <= n_mode;
        r_x0    <= n_x0;
        r_y0    <= n_y0;
        r_x1    <= n_x1;
        r_y1    <= n_y1;
        r_raddr <= n_raddr;
        r_rx    <= n_rx;
        r_ry    <= n_ry;
        r_xc    <= n_xc;
        r_yc    <= n_yc;
        r_x     <= n_x;
        r_y     <= n_y;
        r_rx2   <= n_rx2;
        r_ry2   <= n_ry2;
        r_t     <= n_t;
        r_d     <= n_d;
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_k     <= n_k;
        r_paddr <= n_paddr;
        r_pmask <= n_pmask;
        r_rdata <= n_rdata;
    end

    always_comb begin
        xce = PT_W'(r_xc);
        yce = PT_W'(r_yc);
        xo  = $signed(PT_W'(r_x));
        yo  = PT_W'(r_y);
        if (r_func == FN_SET) begin
            px = PT_W'(r_x0);
            py = PT_W'(r_y0);
        end else begin
            px = r_k[0] ? (xce - xo) : (xce + xo);
            py = r_k[1] ? (yce - yo) : (yce + yo);
        end
        ddx  = 11'(r_x1) - 11'(r_x0);
        ddy  = 11'(r_y1) - 11'(r_y0);
        adx  = ddx[10] ? 11'(-ddx) : 11'(ddx);
        ady  = ddy[10] ? 11'(-ddy) : 11'(ddy);
        ym1  = r_y - 12'sd1;
        aym1 = ym1[11] ? 12'(-ym1) : 12'(ym1);
        rd_hit = (32'(r_raddr) < 32'(STORE_BYTES));

        case (r_state)
            ST_E_RX2: begin
                m_a = MUL_W'(r_rx);
                m_b = MUL_W'(r_rx);
            end
            ST_E_RY2: begin
                m_a = MUL_W'(r_ry);
                m_b = MUL_W'(r_ry);
            end
            ST_E_T: begin
                m_a = r_rx2[MUL_W-1:0];
                m_b = MUL_W'(r_ry);
            end
            ST_D2_A: begin
                m_a = MUL_W'({r_x, 1'b1});
                m_b = MUL_W'({r_x, 1'b1});
            end
            ST_D2_B: begin
                m_a = r_ry2[MUL_W-1:0];
                m_b = r_t[MUL_W-1:0];
            end
            ST_D2_C: begin
                m_a = MUL_W'(aym1);
                m_b = MUL_W'(aym1);
            end
            ST_D2_D: begin
                m_a = r_rx2[MUL_W-1:0];
                m_b = r_t[MUL_W-1:0];
            end
            ST_D2_E: begin
                m_a = r_rx2[MUL_W-1:0];
                m_b = r_ry2[MUL_W-1:0];
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
        m_p = m_a * m_b;
        pe  = $signed(DEC_W'(m_p));
        te  = $signed(DEC_W'(r_t));
        dxn = r_dx + (r_ry2 <<< 1);
        dyn = r_dy - (r_rx2 <<< 1);

        case (r_mode)
            MD_OR:     wbyte = i_rdata | r_pmask;
            MD_ANDNOT: wbyte = i_rdata & ~r_pmask;
            MD_XOR:    wbyte = i_rdata ^ r_pmask;
            default:   wbyte = i_rdata;
        endcase

        n_state   = r_state;
        n_ret     = r_ret;
        n_clr     = r_clr;
        n_clr_cmd = r_clr_cmd;
        n_func    = r_func;
        n_mode    = r_mode;
        n_x0      = r_x0;
        n_y0      = r_y0;
        n_x1      = r_x1;
        n_y1      = r_y1;
        n_raddr   = r_raddr;
        n_rx      = r_rx;
        n_ry      = r_ry;
        n_xc      = r_xc;
        n_yc      = r_yc;
        n_x       = r_x;
        n_y       = r_y;
        n_rx2     = r_rx2;
        n_ry2     = r_ry2;
        n_t       = r_t;
        n_d       = r_d;
        n_dx      = r_dx;
        n_dy      = r_dy;
        n_k       = r_k;
        n_paddr   = r_paddr;
        n_pmask   = r_pmask;
        n_rdata   = r_rdata;
        o_req     = '0;
        o_done    = '0;

        case (r_state)
            ST_CLEAR: begin
                o_req.we   = 1'b1;
                o_req.addr = r_clr;
                n_clr      = r_clr + 1'b1;
                if (32'(r_clr) == STORE_BYTES - 1) begin
                    n_clr     = '0;
                    n_clr_cmd = 1'b0;
                    n_state   = r_clr_cmd ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_func  = t_func'(i_cmd.func);
                    n_mode  = t_mode'(i_cmd.draw_mode);
                    n_x0    = i_cmd.corner_x0;
                    n_y0    = i_cmd.corner_y0;
                    n_x1    = i_cmd.corner_x1;
                    n_y1    = i_cmd.corner_y1;
                    n_raddr = i_cmd.read_address;
                    n_rdata = '0;
                    case (t_func'(i_cmd.func))
                        FN_SET: begin
                            n_k     = 2'd3;
                            n_ret   = ST_DONE;
                            n_state = ST_PX_RD;
                        end
                        FN_ELLIPSE: n_state = ST_E_GEO;
                        FN_READ:    n_state = ST_RD_ISSUE;
                        default: begin
                            n_clr     = '0;
                            n_clr_cmd = 1'b1;
                            n_state   = ST_CLEAR;
                        end
                    endcase
                end
            end
            ST_RD_ISSUE: begin
                o_req.re   = rd_hit;
                o_req.addr = ADDR_W'(r_raddr);
                n_state    = ST_RD_WAIT;
            end
            ST_RD_WAIT: begin
                n_rdata = rd_hit ? i_rdata : 8'd0;
                n_state = ST_DONE;
            end
            ST_E_GEO: begin
                n_rx    = adx[10:1];
                n_ry    = ady[10:1];
                n_xc    = 12'(r_x0) + $signed({2'b00, adx[10:1]});
                n_yc    = 12'(r_y0) + $signed({2'b00, ady[10:1]});
                n_state = ST_E_RX2;
            end
            ST_E_RX2: begin
                n_rx2   = pe;
                n_state = ST_E_RY2;
            end
            ST_E_RY2: begin
                n_ry2   = pe;
                n_state = ST_E_T;
            end
            ST_E_T: begin
                n_t     = m_p;
                n_state = ST_E_INIT;
            end
            ST_E_INIT: begin
                n_x     = '0;
                n_y     = $signed({2'b00, r_ry});
                n_dx    = '0;
                n_dy    = te <<< 1;
                n_d     = (r_ry2 <<< 2) - (te <<< 2) + r_rx2;
                n_state = ST_R1_TEST;
            end
            ST_R1_TEST: begin
                if (r_dx < r_dy) begin
                    n_k     = 2'd0;
                    n_ret   = ST_R1_UPD;
                    n_state = ST_PX_RD;
                end else begin
                    n_state = ST_D2_A;
                end
            end
            ST_R1_UPD: begin
                n_x  = r_x + 11'd1;
                n_dx = dxn;
                if (r_d[DEC_W-1]) begin
                    n_d = r_d + (dxn <<< 2) + (r_ry2 <<< 2);
                end else begin
                    n_y  = r_y - 12'sd1;
                    n_dy = dyn;
                    n_d  = r_d + (dxn <<< 2) - (dyn <<< 2) + (r_ry2 <<< 2);
                end
                n_state = ST_R1_TEST;
            end
            ST_D2_A: begin
                n_t     = m_p;
                n_state = ST_D2_B;
            end
            ST_D2_B: begin
                n_d     = pe;
                n_state = ST_D2_C;
            end
            ST_D2_C: begin
                n_t     = m_p;
                n_state = ST_D2_D;
            end
            ST_D2_D: begin
                n_d     = r_d + (pe <<< 2);
                n_state = ST_D2_E;
            end
            ST_D2_E: begin
                n_d     = r_d - (pe <<< 2);
                n_state = ST_R2_TEST;
            end
            ST_R2_TEST: begin
                if (!r_y[11]) begin
                    n_k     = 2'd0;
                    n_ret   = ST_R2_UPD;
                    n_state = ST_PX_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_R2_UPD: begin
                n_y  = r_y - 12'sd1;
                n_dy = dyn;
                if (!r_d[DEC_W-1] && (r_d != '0)) begin
                    n_d = r_d + (r_rx2 <<< 2) - (dyn <<< 2);
                end else begin
                    n_x  = r_x + 11'd1;
                    n_dx = dxn;
                    n_d  = r_d + (dxn <<< 2) - (dyn <<< 2) + (r_rx2 <<< 2);
                end
                n_state = ST_R2_TEST;
            end
            ST_PX_RD: begin
                if (pix.hit) begin
                    o_req.re   = 1'b1;
                    o_req.addr = pix.addr;
                    n_paddr    = pix.addr;
                    n_pmask    = pix.mask;
                    n_state    = ST_PX_WR;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = (r_k == 2'd3) ? r_ret : ST_PX_RD;
                end
            end
            ST_PX_WR: begin
                o_req.we    = 1'b1;
                o_req.addr  = r_paddr;
                o_req.wdata = wbyte;
                n_k         = r_k + 2'd1;
                n_state     = (r_k == 2'd3) ? r_ret : ST_PX_RD;
            end
            ST_DONE: begin
                if (i_rsp_free) begin
                    o_done.done      = 1'b1;
                    o_done.read_data = r_rdata;
                    n_state          = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

### tb/monochrome_framebuffer_ellipse_drawer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// monochrome_framebuffer_ellipse_drawer_tb
// Self-checking bench for the frame store drawing engine. A directed table
// covers the panel edges, clipping, every draw mode and the ellipse corner
// cases. Random commands follow in three phases of handshake pressure and
// panel height. A local model of the frame store predicts every read byte.
// ----------------------------------------------------------------------------
module monochrome_framebuffer_ellipse_drawer_tb;
    import mfed_pkg::*;

    typedef struct {
        t_func             fn;
        logic signed [9:0] x0;
        logic signed [9:0] y0;
        logic signed [9:0] x1;
        logic signed [9:0] y1;
        t_mode             md;
        logic [9:0]        addr;
        bit                typed;
        logic [7:0]        typed_data;
    } t_cmd;

    typedef struct {
        logic [7:0] data;
        logic       done;
    } t_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;

    mfed_cmd_if cmd_ch();
    mfed_rsp_if rsp_ch();

    monochrome_framebuffer_ellipse_drawer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_cmd      (cmd_ch),
        .o_rsp      (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    logic [7:0] store_model [STORE_BYTES];
    bit         half_rows;
    t_rsp       pending_rsp[$];
    int         n_errors;
    int         n_checked;
    int         n_ellipses;
    int         idle_tx;
    int         idle_rx;

    function automatic void plot_pixel(longint x, longint y, t_mode md);
        longint rows;
        longint row;
        logic [7:0] bits;
        longint idx;
        rows = half_rows ? ROWS_HALF : ROWS_FULL;
        if (x < 0 || x >= PANEL_WIDTH || y < 0 || y >= rows) return;
        row = half_rows ? 2 * y + 1 : y;
        bits = 8'd1 << row[2:0];
        if (half_rows) bits = bits | (bits >> 1);
        idx = x + (row >>> 3) * PANEL_WIDTH;
        if (idx >= STORE_BYTES) return;
        case (md)
            MD_OR:     store_model[idx] = store_model[idx] | bits;
            MD_ANDNOT: store_model[idx] = store_model[idx] & ~bits;
            MD_XOR:    store_model[idx] = store_model[idx] ^ bits;
            default:   ;
        endcase
    endfunction

    function automatic void plot_quad(longint x, longint y, longint xc, longint yc, t_mode md);
        plot_pixel(xc + x, yc + y, md);
        plot_pixel(xc - x, yc + y, md);
        plot_pixel(xc + x, yc - y, md);
        plot_pixel(xc - x, yc - y, md);
    endfunction

    function automatic void trace_ellipse(t_cmd c);
        longint ddx, ddy, rx, ry, xc, yc, rx2, ry2, x, y, dx, dy, d1, d2;
        ddx = longint'(c.x1) - longint'(c.x0);
        ddy = longint'(c.y1) - longint'(c.y0);
        rx = (ddx < 0 ? -ddx : ddx) / 2;
        ry = (ddy < 0 ? -ddy : ddy) / 2;
        xc = longint'(c.x0) + rx;
        yc = longint'(c.y0) + ry;
        rx2 = rx * rx;
        ry2 = ry * ry;
        x = 0;
        y = ry;
        dx = 0;
        dy = 2 * rx2 * y;
        d1 = 4 * ry2 - 4 * rx2 * ry + rx2;
        while (dx < dy) begin
            plot_quad(x, y, xc, yc, c.md);
            x++;
            dx += 2 * ry2;
            if (d1 < 0) begin
                d1 += 4 * dx + 4 * ry2;
            end else begin
                y--;
                dy -= 2 * rx2;
                d1 += 4 * dx - 4 * dy + 4 * ry2;
            end
        end
        d2 = ry2 * (2 * x + 1) * (2 * x + 1) + 4 * rx2 * (y - 1) * (y - 1) - 4 * rx2 * ry2;
        while (y >= 0) begin
            plot_quad(x, y, xc, yc, c.md);
            y--;
            dy -= 2 * rx2;
            if (d2 > 0) begin
                d2 += 4 * rx2 - 4 * dy;
            end else begin
                x++;
                dx += 2 * ry2;
                d2 += 4 * dx - 4 * dy + 4 * rx2;
            end
        end
    endfunction

    function automatic logic [7:0] run_command(t_cmd c);
        logic [7:0] data;
        data = 8'd0;
        case (c.fn)
            FN_SET:     plot_pixel(longint'(c.x0), longint'(c.y0), c.md);
            FN_ELLIPSE: trace_ellipse(c);
            FN_READ:    data = store_model[c.addr];
            default:    foreach (store_model[i]) store_model[i] = 8'd0;
        endcase
        return data;
    endfunction

    function automatic t_cmd make_cmd(t_func fn, int x0, int y0, int x1, int y1,
                                      t_mode md, int addr, bit typed, int typed_data);
        t_cmd c;
        c.fn = fn;
        c.x0 = 10'(x0);
        c.y0 = 10'(y0);
        c.x1 = 10'(x1);
        c.y1 = 10'(y1);
        c.md = md;
        c.addr = 10'(addr);
        c.typed = typed;
        c.typed_data = 8'(typed_data);
        return c;
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int pick;
        int ox;
        int oy;
        c.x0 = 10'($urandom);
        c.y0 = 10'($urandom);
        c.x1 = 10'($urandom);
        c.y1 = 10'($urandom);
        c.md = t_mode'($urandom_range(3));
        c.addr = 10'($urandom);
        c.typed = 1'b0;
        c.typed_data = 8'd0;
        pick = $urandom_range(99);
        if (pick < 3) begin
            c.fn = FN_CLEAR;
        end else if (pick < 40) begin
            c.fn = FN_READ;
        end else if (pick < 75) begin
            c.fn = FN_SET;
            if ($urandom_range(3) != 0) begin
                c.x0 = 10'($urandom_range(PANEL_WIDTH + 3) - 2);
                c.y0 = 10'($urandom_range(ROWS_FULL + 3) - 2);
            end
        end else begin
            c.fn = FN_ELLIPSE;
            if ($urandom_range(9) != 0) begin
                ox = $urandom_range(PANEL_WIDTH + 40) - 20;
                oy = $urandom_range(ROWS_FULL + 20) - 10;
                c.x0 = 10'(ox);
                c.y0 = 10'(oy);
                c.x1 = 10'(ox + $urandom_range(80) - 40);
                c.y1 = 10'(oy + $urandom_range(60) - 30);
            end
        end
        if (c.md == MD_KEEP && $urandom_range(3) != 0) c.md = MD_XOR;
        return c;
    endfunction

    task automatic send_cmd(t_cmd c);
        logic [7:0] data;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_tx) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.func <= c.fn;
        cmd_ch.corner_x0 <= c.x0;
        cmd_ch.corner_y0 <= c.y0;
        cmd_ch.corner_x1 <= c.x1;
        cmd_ch.corner_y1 <= c.y1;
        cmd_ch.draw_mode <= c.md;
        cmd_ch.read_address <= c.addr;
        do @(posedge i_clk); while (!cmd_ch.ready);
        data = run_command(c);
        if (c.typed) data = c.typed_data;
        if (c.fn == FN_ELLIPSE) n_ellipses++;
        pending_rsp.push_back('{data: data, done: 1'b1});
    endtask

    task automatic drain_and_hold();
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_panel_mode(bit value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        half_rows = value;
    endtask

    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= idle_rx);
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                $error("unexpected result item: read_data %0h", rsp_ch.read_data);
                n_errors++;
            end else begin
                want = pending_rsp.pop_front();
                n_checked++;
                if (rsp_ch.read_data !== want.data) begin
                    $error("read_data expected %0h actual %0h", want.data, rsp_ch.read_data);
                    n_errors++;
                end
                if (rsp_ch.command_done !== want.done) begin
                    $error("command_done expected %0b actual %0b", want.done,
                           rsp_ch.command_done);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        #200ms;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        t_cmd directed[$];
        cmd_ch.valid = 1'b0;
        cmd_ch.func = FN_READ;
        cmd_ch.corner_x0 = '0;
        cmd_ch.corner_y0 = '0;
        cmd_ch.corner_x1 = '0;
        cmd_ch.corner_y1 = '0;
        cmd_ch.draw_mode = MD_OR;
        cmd_ch.read_address = '0;
        rsp_ch.ready = 1'b0;
        n_errors = 0;
        n_checked = 0;
        n_ellipses = 0;
        idle_tx = 0;
        idle_rx = 0;
        half_rows = 1'b0;
        foreach (store_model[i]) store_model[i] = 8'd0;

        directed = '{
            make_cmd(FN_READ,    0,    0,   0,   0,   MD_OR,     0,    1, 8'h00),
            make_cmd(FN_READ,    0,    0,   0,   0,   MD_OR,     1023, 1, 8'h00),
            make_cmd(FN_SET,     0,    0,   0,   0,   MD_OR,     0,    0, 0),
            make_cmd(FN_READ,    0,    0,   0,   0,   MD_OR,     0,    1, 8'h01),
            make_cmd(FN_SET,     127,  63,  0,   0,   MD_OR,     0,    0, 0),
            make_cmd(FN_READ,    0,    0,   0,   0,   MD_OR,     1023, 1, 8'h80),
            make_cmd(FN_SET,     -1,   0,   0,   0,   MD_OR,     0,    0, 0),
            make_cmd(FN_SET,     128,  0,   0,   0,   MD_OR,     0,    0, 0),
            make_cmd(FN_SET,     0,    64,  0,   0,   MD_OR,     0,    0, 0),
            make_cmd(FN_SET,     -512, 511, 0,   0,   MD_OR,     0,    0, 0),
            make_cmd(FN_SET,     0,    0,   0,   0,   MD_XOR,    0,    0, 0),
            make_cmd(FN_READ,    0,    0,   0,   0,   MD_OR,     0,    1, 8'h00),
            make_cmd(FN_SET,     127,  63,  0,   0,   MD_KEEP,   0,    0, 0),
            make_cmd(FN_SET,     127,  63,  0,   0,   MD_ANDNOT, 0,    0, 0),
            make_cmd(FN_READ,    0,    0,   0,   0,   MD_OR,     1023, 1, 8'h00),
            make_cmd(FN_ELLIPSE, 10,   10,  40,  30,  MD_OR,     0,    0, 0),
            make_cmd(FN_ELLIPSE, 100,  50,  70,  20,  MD_XOR,    0,    0, 0),
            make_cmd(FN_ELLIPSE, 5,    5,   5,   5,   MD_XOR,    0,    0, 0),
            make_cmd(FN_ELLIPSE, 60,   2,   61,  40,  MD_OR,     0,    0, 0),
            make_cmd(FN_ELLIPSE, -512, -512, 511, 511, MD_XOR,   0,    0, 0),
            make_cmd(FN_READ,    0,    0,   0,   0,   MD_OR,     133,  0, 0),
            make_cmd(FN_READ,    0,    0,   0,   0,   MD_OR,     403,  0, 0),
            make_cmd(FN_CLEAR,   0,    0,   0,   0,   MD_OR,     0,    0, 0),
            make_cmd(FN_READ,    0,    0,   0,   0,   MD_OR,     133,  1, 8'h00)
        };

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_panel_mode(1'b0);

        foreach (directed[i]) send_cmd(directed[i]);

        for (int phase = 0; phase < 3; phase++) begin
            drain_and_hold();
            write_panel_mode(phase != 1);
            idle_tx = (phase == 0) ? 12 : (phase == 1) ? 86 : 0;
            idle_rx = (phase == 0) ? 86 : (phase == 1) ? 12 : 0;
            repeat (170) send_cmd(random_cmd());
        end
        drain_and_hold();

        $display("Checked %0d result items, %0d of them from ellipse commands,",
                 n_checked, n_ellipses);
        $display("over both panel heights and three handshake pressure phases.");
        if (n_errors == 0 && pending_rsp.size() == 0) begin
            $display("TB_OK");
        end else begin
            if (pending_rsp.size() != 0)
                $error("%0d expected result items never arrived", pending_rsp.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
